>>> rtl/core/vtrds_pkg.sv
// Shared types and constants for the value table block.
// Used by the controller, the output stage and the top level; no dependencies.
package vtrds_pkg;

    // Default number of table slots
    localparam int DEPTH_DEF = 16;

    // Fixed widths of the item fields
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    // Action selector carried with each input item
    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_REPLACE = 2'd1,
        ACT_DELETE  = 2'd2,
        ACT_SEARCH  = 2'd3
    } t_action;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // One result item as handed from the controller to the output stage
    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   index;
        logic [COUNT_W-1:0]   count;
    } t_result;

endpackage

>>> rtl/core/vtrds_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No package dependencies.
module vtrds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/vtrds_obuf.sv
// Output register stage for result items; frees the controller from the receiver.
// Depends on vtrds_pkg for the result type.
module vtrds_obuf
    import vtrds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_res_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Room for a new item when empty or when the held item leaves now
    assign o_res_free = !r_valid || i_ready;

    // Hold the item until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> rtl/core/vtrds_ctrl.sv
// Controller: action decode, pipelined table scan with read-modify-write, fill count.
// Depends on vtrds_pkg; drives the ports of one vtrds_ram instance.
module vtrds_ctrl
    import vtrds_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input items
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_action                  i_action,
    input  logic [VALUE_W-1:0]       i_value,
    input  logic [VALUE_W-1:0]       i_new_value,
    // Table memory
    output logic                     o_mem_we,
    output logic [$clog2(DEPTH)-1:0] o_mem_waddr,
    output logic [VALUE_W-1:0]       o_mem_wdata,
    output logic                     o_mem_re,
    output logic [$clog2(DEPTH)-1:0] o_mem_raddr,
    input  logic [VALUE_W-1:0]       i_mem_rdata,
    // Result items
    output logic                     o_res_valid,
    output t_result                  o_res,
    input  logic                     i_res_free
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state             r_state,   n_state;
    t_action            r_act,     n_act;
    logic [VALUE_W-1:0] r_key,     n_key;
    logic [VALUE_W-1:0] r_repl,    n_repl;
    logic [CW-1:0]      r_count,   n_count;
    logic [CW-1:0]      r_rd_idx,  n_rd_idx;
    logic               r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]      r_cmp_idx, n_cmp_idx;
    logic               r_found,   n_found;
    t_status            r_status,  n_status;
    logic [AW-1:0]      r_index,   n_index;

    logic               more;
    logic               hit;
    logic               drop_one;
    logic [CW-1:0]      count_after;
    logic [AW+INDEX_W-1:0] index_ext;
    logic [CW+COUNT_W-1:0] count_ext;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_key     <= n_key;
        r_repl    <= n_repl;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_found   <= n_found;
        r_status  <= n_status;
        r_index   <= n_index;
    end

    assign more     = (r_rd_idx < r_count);
    assign hit      = r_cmp_vld && (i_mem_rdata == r_key);
    assign drop_one = (r_act == ACT_DELETE) && r_found;

    // Result fields, cut or widened to the fixed item widths
    assign count_after = drop_one ? (r_count - CW'(1)) : r_count;
    assign index_ext   = {{INDEX_W{1'b0}}, r_index};
    assign count_ext   = {{COUNT_W{1'b0}}, count_after};

    assign o_res.status = r_status;
    assign o_res.index  = index_ext[INDEX_W-1:0];
    assign o_res.count  = count_ext[COUNT_W-1:0];

    // Next state, scan and memory access
    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_key       = r_key;
        n_repl      = r_repl;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_found     = r_found;
        n_status    = r_status;
        n_index     = r_index;
        o_in_ready  = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cmp_idx;
        o_mem_wdata = r_repl;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_rd_idx[AW-1:0];
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_act    = i_action;
                    n_key    = i_value;
                    n_repl   = i_new_value;
                    n_rd_idx = '0;
                    n_found  = 1'b0;
                    n_index  = '0;
                    if (i_action == ACT_APPEND) begin
                        n_state = S_DONE;
                        if (r_count == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            // Store at the next free slot
                            o_mem_we    = 1'b1;
                            o_mem_waddr = r_count[AW-1:0];
                            o_mem_wdata = i_value;
                            n_index     = r_count[AW-1:0];
                            n_count     = r_count + CW'(1);
                            n_status    = ST_OK;
                        end
                    end else begin
                        n_state  = S_SCAN;
                        n_status = ST_NONE;
                    end
                end
            end

            S_SCAN: begin
                // Act on the entry whose read data arrives now
                if (r_cmp_vld) begin
                    case (r_act)
                        ACT_REPLACE: begin
                            if (hit) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_cmp_idx;
                                o_mem_wdata = r_repl;
                                n_status    = ST_OK;
                            end
                        end
                        ACT_DELETE: begin
                            if (r_found) begin
                                // Shift the entry down by one slot
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_cmp_idx - AW'(1);
                                o_mem_wdata = i_mem_rdata;
                            end else if (hit) begin
                                n_found  = 1'b1;
                                n_index  = r_cmp_idx;
                                n_status = ST_OK;
                            end
                        end
                        ACT_SEARCH: begin
                            if (hit) begin
                                n_index  = r_cmp_idx;
                                n_status = ST_OK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // Stop on the first search hit or when all entries are through
                if ((r_act == ACT_SEARCH && hit) || !more) begin
                    n_state = S_DONE;
                end else begin
                    o_mem_re  = 1'b1;
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx[AW-1:0];
                end
            end

            S_DONE: begin
                // Hand over the result once the output stage has room
                o_res_valid = 1'b1;
                if (i_res_free) begin
                    n_count = count_after;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/value_table_replace_delete_search.sv
// Top level of the value table: stream ports, controller, table memory, output stage.
// Depends on vtrds_pkg, vtrds_ram, vtrds_ctrl and vtrds_obuf.
//
// Usage:
//   Slave channel s_axis carries one command item: tuser holds the action
//   (append, replace all matches, delete first match, search first match),
//   tdata holds the value and the replacement value. Master channel m_axis
//   returns exactly one result item per command: tuser holds the status
//   (done/found, no match, table full), tdata holds the index and the count.
//   An append writes its slot as it is accepted and needs no scan. Replace and delete
//   scan all stored entries; search stops at its first hit, else scans them all.
//   One item is in work at a time; the rate is set by the scan, which reads
//   one stored entry per cycle from the single read port of the table RAM.
//   Delete shifts later entries down during the same pass as the search.
//   Reset empties the table at once (fill count to zero); no clearing pass.
//   A stalled receiver holds the result in the output register; the next
//   command is still accepted and runs up to its own result, then waits.
module value_table_replace_delete_search
    import vtrds_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] value, [63:32] new_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] index, [8:4] count, [15:9] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int AW = $clog2(DEPTH);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;
    logic               res_valid;
    logic               res_free;
    t_result            res;
    t_result            out_res;

    vtrds_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (t_action'(s_axis_tuser)),
        .i_value     (s_axis_tdata[31:0]),
        .i_new_value (s_axis_tdata[63:32]),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_free  (res_free)
    );

    vtrds_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    vtrds_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_free  (res_free),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (out_res)
    );

    // Pack the result fields onto the stream
    assign m_axis_tuser = out_res.status;
    assign m_axis_tdata = {7'd0, out_res.count, out_res.index};

endmodule

>>> verif/value_table_replace_delete_search_test.sv
// Self-checking testbench for value_table_replace_delete_search: directed and random
// append, replace, delete and search items, checked against a table predictor.
// Depends on vtrds_pkg and the value_table_replace_delete_search RTL only.
module value_table_replace_delete_search_test;
    import vtrds_pkg::*;

    localparam int SLOTS        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1550;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 40;

    // Predicts each result from its own copy of the table and checks arrivals
    class value_table_check;
        logic [VALUE_W-1:0] slots [SLOTS];
        int                 fill;
        t_result            expected_results [$];
        int                 errors;

        task report_mismatch(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            errors++;
        endtask

        // Slot of the first entry equal to key, or -1
        function int first_hit(logic [VALUE_W-1:0] key);
            for (int i = 0; i < fill; i++) begin
                if (slots[i] == key) return i;
            end
            return -1;
        endfunction

        // Apply one accepted command to the table and queue its result
        function void predict_command(t_action act, logic [VALUE_W-1:0] key,
                                      logic [VALUE_W-1:0] repl);
            t_result r;
            int      pos;
            bit      hit;
            r.status = ST_OK;
            r.index  = '0;
            case (act)
                ACT_APPEND: begin
                    if (fill >= SLOTS) begin
                        r.status = ST_FULL;
                    end else begin
                        slots[fill] = key;
                        r.index = INDEX_W'(fill);
                        fill++;
                    end
                end
                ACT_REPLACE: begin
                    hit = 1'b0;
                    for (int i = 0; i < fill; i++) begin
                        if (slots[i] == key) begin
                            slots[i] = repl;
                            hit = 1'b1;
                        end
                    end
                    if (!hit) r.status = ST_NONE;
                end
                ACT_DELETE: begin
                    pos = first_hit(key);
                    if (pos < 0) begin
                        r.status = ST_NONE;
                    end else begin
                        for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
                        fill--;
                        r.index = INDEX_W'(pos);
                    end
                end
                default: begin
                    pos = first_hit(key);
                    if (pos < 0) r.status = ST_NONE;
                    else r.index = INDEX_W'(pos);
                end
            endcase
            r.count = COUNT_W'(fill);
            expected_results.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        task check_result(logic [1:0] status, logic [15:0] data);
            t_result e;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d data %h", status, data));
                return;
            end
            e = expected_results.pop_front();
            if (status != e.status)
                report_mismatch($sformatf("status %0d, want %0d", status, e.status));
            if (data[3:0] != e.index)
                report_mismatch($sformatf("index %0d, want %0d", data[3:0], e.index));
            if (data[8:4] != e.count)
                report_mismatch($sformatf("count %0d, want %0d", data[8:4], e.count));
            if (data[15:9] != '0)
                report_mismatch($sformatf("tdata padding %h not zero", data[15:9]));
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;    // [31:0] value, [63:32] new_value
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [3:0] index, [8:4] count, [15:9] zero
    logic [1:0]  m_axis_tuser;          // [1:0] status

    value_table_check   table_chk = new;
    int                 items_sent;
    int                 results_seen;
    int                 idle_cycles;
    logic [VALUE_W-1:0] key_pool [8];
    logic [VALUE_W-1:0] recent_vals [16];
    int                 recent_wr;

    value_table_replace_delete_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Record accepted items on both sides at the clock edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                table_chk.predict_command(t_action'(s_axis_tuser), s_axis_tdata[31:0],
                                          s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready) begin
                table_chk.check_result(m_axis_tuser, m_axis_tdata);
                results_seen++;
            end
        end
    end

    // Abort when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("value_table_replace_delete_search_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, one long hold-off, one stretch always ready
    initial begin
        bit held;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!held && results_seen >= 300) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end
            if (results_seen >= 1000 && results_seen < 1200)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 28);
        end
    end

    // Offer one command and hold it until accepted; idle first at random
    task automatic send_command(t_action act, logic [VALUE_W-1:0] key,
                                logic [VALUE_W-1:0] repl);
        bit calm;
        calm = (items_sent >= 700 && items_sent < 900);
        if (!calm && $urandom_range(0, 99) < 28) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 28);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {repl, key};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Pick a value: mostly ones likely stored, sometimes any pattern
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return key_pool[$urandom_range(0, 7)];
        if (r < 80) return recent_vals[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    task automatic note_stored(logic [VALUE_W-1:0] v);
        recent_vals[recent_wr] = v;
        recent_wr = (recent_wr + 1) % 16;
    endtask

    // Edge cases: empty table, extreme values, replace, delete, full table
    task automatic run_directed();
        send_command(ACT_SEARCH, 32'h0000_0000, $urandom);
        send_command(ACT_DELETE, 32'hFFFF_FFFF, $urandom);
        send_command(ACT_APPEND, 32'h8000_0000, 32'hFFFF_FFFF);
        send_command(ACT_APPEND, 32'h7FFF_FFFF, 32'h0000_0000);
        send_command(ACT_APPEND, 32'h0000_0000, $urandom);
        send_command(ACT_APPEND, 32'hFFFF_FFFF, $urandom);
        send_command(ACT_SEARCH, 32'h7FFF_FFFF, $urandom);
        // two entries end up holding the minimum value
        send_command(ACT_REPLACE, 32'hFFFF_FFFF, 32'h8000_0000);
        // new value equal to the matched one
        send_command(ACT_REPLACE, 32'h0000_0000, 32'h0000_0000);
        send_command(ACT_DELETE, 32'h8000_0000, $urandom);
        send_command(ACT_SEARCH, 32'h1234_5678, $urandom);
        for (int k = 0; k < 12; k++) send_command(ACT_APPEND, key_pool[k % 8], $urandom);
        send_command(ACT_APPEND, 32'h5A5A_A5A5, $urandom);
        send_command(ACT_APPEND, 32'h0F0F_0F0F, $urandom);
        // remove the entry in the last slot
        send_command(ACT_DELETE, 32'h5A5A_A5A5, $urandom);
    endtask

    // Alternate fill-biased and drain-biased phases so the count sweeps its range
    task automatic run_random();
        int               r;
        bit               filling;
        t_action          act;
        logic [VALUE_W-1:0] key;
        logic [VALUE_W-1:0] repl;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            filling = ((n / 120) % 2) == 0;
            r = $urandom_range(0, 99);
            if (filling)
                act = (r < 50) ? ACT_APPEND : (r < 65) ? ACT_REPLACE :
                      (r < 80) ? ACT_DELETE : ACT_SEARCH;
            else
                act = (r < 15) ? ACT_APPEND : (r < 30) ? ACT_REPLACE :
                      (r < 75) ? ACT_DELETE : ACT_SEARCH;
            key  = pick_value();
            repl = ($urandom_range(0, 99) < 70) ? key_pool[$urandom_range(0, 7)] : $urandom;
            if (act == ACT_APPEND) note_stored(key);
            if (act == ACT_REPLACE) note_stored(repl);
            send_command(act, key, repl);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int k = 4; k < 8; k++) key_pool[k] = $urandom;
        for (int k = 0; k < 16; k++) recent_vals[k] = key_pool[k % 8];
        recent_wr = 0;

        // Hold reset, then release it on a clock edge
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random();

        // Let the last accepted item reach the predictor, then drain results
        @(posedge i_clk);
        while (table_chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (table_chk.errors == 0)
            $display("value_table_replace_delete_search_test: done, clean");
        else
            $display("value_table_replace_delete_search_test: done, errors");
        $finish;
    end

endmodule
